[design/lafa_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and codes for the local affinity feature assembly.
// No dependencies; lafa_norm, the top level and the testbench refer to it by scoped names.
package lafa_pkg;

    // Default sizing of the top level
    localparam int MAX_HEIGHT_DEF   = 64;
    localparam int MAX_WIDTH_DEF    = 64;
    localparam int MAX_CHANNELS_DEF = 16;
    localparam int MAX_PAD_DEF      = 2;

    // Fixed field and datapath widths
    localparam int FEAT_W    = 16;
    localparam int AFF_W     = 16;
    localparam int ACC_W     = 48;
    localparam int SQ_W      = 40;
    localparam int ROOT_W    = 20;
    localparam int NUM_W     = 57;
    localparam int RES_W     = 32;
    localparam int IDX_W     = 5;
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;
    localparam int STEP_W    = 6;
    localparam int ROOT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = NUM_W;

    // Register reset values
    localparam logic [6:0] MAP_HEIGHT_RST    = 7'd64;
    localparam logic [6:0] MAP_WIDTH_RST     = 7'd64;
    localparam logic [1:0] WINDOW_PAD_RST    = 2'd1;
    localparam logic [4:0] CHANNEL_COUNT_RST = 5'd16;

    typedef enum logic [1:0] {
        REG_MAP_HEIGHT,
        REG_MAP_WIDTH,
        REG_WINDOW_PAD,
        REG_CHANNEL_COUNT
    } reg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_ACC,
        S_DRAIN,
        S_ROOT_GO,
        S_ROOT_WAIT,
        S_EMIT_RD,
        S_EMIT_GO,
        S_EMIT_WAIT,
        S_EMIT_PUT
    } state_t;

    typedef enum logic [1:0] {
        NORM_IDLE,
        NORM_ROOT,
        NORM_DIV
    } norm_state_t;

    // Request to the root and divide unit
    typedef struct packed {
        logic             go_root;
        logic             go_div;
        logic [SQ_W-1:0]  square;
        logic             neg;
        logic [NUM_W-1:0] mag;
    } norm_req_t;

    // Status back from the root and divide unit
    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] value;
    } norm_stat_t;

endpackage

[design/lafa_item_if.sv]
`timescale 1ns / 1ps
// Input channel of the feature assembly: valid/ready plus one item's fields.
// Uses no package.
interface lafa_item_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [5:0]         pixel_row;
    logic [5:0]         pixel_col;
    logic [3:0]         channel;
    logic signed [15:0] feature_value;
    logic signed [2:0]  offset_row;
    logic signed [2:0]  offset_col;
    logic signed [15:0] affinity;
    logic               window_last;

    modport source (output valid, kind, pixel_row, pixel_col, channel, feature_value,
                    offset_row, offset_col, affinity, window_last, input ready);
    modport sink (input valid, kind, pixel_row, pixel_col, channel, feature_value,
                  offset_row, offset_col, affinity, window_last, output ready);
endinterface

[design/lafa_result_if.sv]
`timescale 1ns / 1ps
// Result channel of the feature assembly: valid/ready plus one result's fields.
// Uses no package.
interface lafa_result_if;
    logic               valid;
    logic               ready;
    logic               result_kind;
    logic [4:0]         result_index;
    logic signed [31:0] result_value;
    logic               result_last;

    modport source (output valid, result_kind, result_index, result_value, result_last,
                    input ready);
    modport sink (input valid, result_kind, result_index, result_value, result_last,
                  output ready);
endinterface

[design/lafa_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lafa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read one word each cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[design/lafa_norm.sv]
`timescale 1ns / 1ps
// Root and divide unit: bit-serial integer square root of the square sum, then
// rounded, saturated division of each numerator by that root. Depends on lafa_pkg.
module lafa_norm (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lafa_pkg::norm_req_t  req,
    output lafa_pkg::norm_stat_t stat
);
    localparam int SQ_W  = lafa_pkg::SQ_W;
    localparam int RT_W  = lafa_pkg::ROOT_W;
    localparam int NUM_W = lafa_pkg::NUM_W;
    localparam int ST_W  = lafa_pkg::STEP_W;

    lafa_pkg::norm_state_t nst_reg, nst_next;
    logic [ST_W-1:0]  cnt_reg;
    logic [SQ_W-1:0]  s_reg;
    logic [SQ_W:0]    r_reg;
    logic [SQ_W:0]    bit_reg;
    logic [RT_W-1:0]  root_reg;
    logic [NUM_W-1:0] num_reg;
    logic [RT_W:0]    rem_reg;
    logic             neg_reg;
    logic             done_reg;
    logic [31:0]      value_reg;

    logic             root_step, div_step, last_step;
    logic [SQ_W:0]    trial;
    logic             root_ge;
    logic [SQ_W:0]    r_n;
    logic [SQ_W-1:0]  s_n;
    logic [RT_W:0]    rem_sh, rem_n;
    logic             div_ge;
    logic [NUM_W-1:0] q_n;
    logic [31:0]      sat_value;

    // Sequence root steps and divide steps
    always_comb
    begin
        nst_next = nst_reg;
        case (nst_reg)
            lafa_pkg::NORM_IDLE:
            begin
                if (req.go_root)
                    nst_next = lafa_pkg::NORM_ROOT;
                else if (req.go_div)
                    nst_next = lafa_pkg::NORM_DIV;
            end
            lafa_pkg::NORM_ROOT:
            begin
                if (last_step)
                    nst_next = lafa_pkg::NORM_IDLE;
            end
            lafa_pkg::NORM_DIV:
            begin
                if (last_step)
                    nst_next = lafa_pkg::NORM_IDLE;
            end
            default:
                nst_next = lafa_pkg::NORM_IDLE;
        endcase
    end

    // Decode step enables
    always_comb
    begin
        root_step = 1'b0;
        div_step  = 1'b0;
        last_step = 1'b0;
        case (nst_reg)
            lafa_pkg::NORM_ROOT:
            begin
                root_step = 1'b1;
                last_step = (cnt_reg == ST_W'(lafa_pkg::ROOT_STEPS - 1));
            end
            lafa_pkg::NORM_DIV:
            begin
                div_step  = 1'b1;
                last_step = (cnt_reg == ST_W'(lafa_pkg::DIV_STEPS - 1));
            end
            default:
            begin
                root_step = 1'b0;
            end
        endcase
    end

    // One root digit: trial subtract of r + bit
    always_comb
    begin
        trial   = r_reg + bit_reg;
        root_ge = ({1'b0, s_reg} >= trial);
        r_n     = root_ge ? ((r_reg >> 1) + bit_reg) : (r_reg >> 1);
        s_n     = root_ge ? (s_reg - trial[SQ_W-1:0]) : s_reg;
    end

    // One quotient bit: restoring step, then saturate the finished quotient
    always_comb
    begin
        rem_sh = {rem_reg[RT_W-1:0], num_reg[NUM_W-1]};
        div_ge = (rem_sh >= {1'b0, root_reg});
        rem_n  = div_ge ? (rem_sh - {1'b0, root_reg}) : rem_sh;
        q_n    = {num_reg[NUM_W-2:0], div_ge};
        if (!neg_reg)
            sat_value = (q_n > NUM_W'(32'h7fff_ffff)) ? 32'h7fff_ffff : q_n[31:0];
        else
            sat_value = (q_n > NUM_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
                                                              : (32'd0 - q_n[31:0]);
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nst_reg  <= lafa_pkg::NORM_IDLE;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            nst_reg  <= nst_next;
            done_reg <= last_step;
            if (root_step || div_step)
                cnt_reg <= cnt_reg + 1'b1;
            else
                cnt_reg <= '0;
        end
    end

    // Advance the datapath
    always_ff @(posedge clk)
    begin
        if (nst_reg == lafa_pkg::NORM_IDLE)
        begin
            if (req.go_root)
            begin
                s_reg   <= req.square;
                r_reg   <= '0;
                bit_reg <= (SQ_W + 1)'(1) << (2 * (lafa_pkg::ROOT_W - 1));
            end
            if (req.go_div)
            begin
                num_reg <= req.mag + NUM_W'(root_reg >> 1);
                rem_reg <= '0;
                neg_reg <= req.neg;
            end
        end
        if (root_step)
        begin
            s_reg   <= s_n;
            r_reg   <= r_n;
            bit_reg <= bit_reg >> 2;
            if (last_step)
                root_reg <= (r_n == '0) ? RT_W'(1) : r_n[RT_W-1:0];
        end
        if (div_step)
        begin
            num_reg <= q_n;
            rem_reg <= rem_n;
            if (last_step)
                value_reg <= sat_value;
        end
    end

    assign stat.done  = done_reg;
    assign stat.value = value_reg;
endmodule

[design/local_affinity_feature_assembly.sv]
`timescale 1ns / 1ps
// Local affinity feature assembly, top level. Depends on lafa_pkg, lafa_item_if,
// lafa_result_if, lafa_ram and lafa_norm.
//
// Feature loads (kind 0) are written into the feature memory, one per cycle, back
// to back, while the block is idle. An affinity item (kind 1) whose neighbour lies
// inside the map and window reads the feature memory, whose read port fetches one
// channel word per cycle, and each product is accumulated through a
// read-modify-write of the accumulator memory. On the last item of a window the
// block computes the bit-serial square root, then runs the bit-serial divider
// once per result, for channel_count + (2*pad+1)^2 results. The feature memory
// has no clearing pass: a word must be loaded before any window reads it.
module local_affinity_feature_assembly #(
    parameter int MAX_HEIGHT   = lafa_pkg::MAX_HEIGHT_DEF,
    parameter int MAX_WIDTH    = lafa_pkg::MAX_WIDTH_DEF,
    parameter int MAX_CHANNELS = lafa_pkg::MAX_CHANNELS_DEF,
    parameter int MAX_PAD      = lafa_pkg::MAX_PAD_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    lafa_item_if.sink                     item_in,
    lafa_result_if.source                 result_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lafa_pkg::PADDR_W-1:0]  paddr,
    input  logic [lafa_pkg::PDATA_W-1:0]  pwdata,
    output logic [lafa_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    localparam int ACC_W    = lafa_pkg::ACC_W;
    localparam int SQ_W     = lafa_pkg::SQ_W;
    localparam int NUM_W    = lafa_pkg::NUM_W;
    localparam int SLOTS    = (2 * MAX_PAD + 1) * (2 * MAX_PAD + 1);
    localparam int FA_DEPTH = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
    localparam int FA_W     = FA_DEPTH > 1 ? $clog2(FA_DEPTH) : 1;
    localparam int CI_W     = MAX_CHANNELS > 1 ? $clog2(MAX_CHANNELS) : 1;
    localparam int CN_W     = $clog2(MAX_CHANNELS + 1);
    localparam int SX_W     = SLOTS > 1 ? $clog2(SLOTS) : 1;
    localparam int E_W      = $clog2(MAX_CHANNELS + SLOTS);

    // Configuration registers
    logic [6:0] map_height_reg, map_width_reg;
    logic [1:0] window_pad_reg;
    logic [4:0] channel_count_reg;

    lafa_pkg::state_t state_reg, state_next;

    // Item registers
    logic signed [15:0] aff_reg;
    logic [31:0]        sq_prod_reg;
    logic               inrng_reg;
    logic               last_reg;
    logic [SX_W-1:0]    slot_reg;
    logic [FA_W-1:0]    base_reg;
    logic [CI_W-1:0]    ch_reg;

    // Accumulate pipeline
    logic                    p1_vld_reg, p2_vld_reg;
    logic [CI_W-1:0]         p1_ch_reg, p2_ch_reg;
    logic signed [31:0]      prod_reg;
    logic [ACC_W-1:0]        accd_reg;
    logic [MAX_CHANNELS-1:0] acc_vld_reg;

    // Per-cell state
    logic [SQ_W-1:0]    sq_sum_reg;
    logic signed [15:0] slot_val_reg [SLOTS];

    // Emission
    logic [E_W-1:0]  e_reg;
    logic [31:0]     res_hold_reg;
    logic            out_valid_reg;
    logic            out_kind_reg;
    logic [4:0]      out_index_reg;
    logic [31:0]     out_value_reg;
    logic            out_last_reg;

    // Memory ports
    logic             feat_we;
    logic [FA_W-1:0]  feat_waddr, feat_raddr;
    logic [15:0]      feat_rdata;
    logic             acc_we;
    logic [CI_W-1:0]  acc_raddr;
    logic [ACC_W-1:0] acc_wdata, acc_rdata;

    lafa_pkg::norm_req_t  norm_req;
    lafa_pkg::norm_stat_t norm_stat;

    // Clamped configuration
    logic [8:0]      h_lim, w_lim;
    logic [1:0]      pad;
    logic [2:0]      k_val;
    logic [4:0]      k2;
    logic [CN_W-1:0] dch;

    // Accept-time decode
    logic               accept, accept_aff, load_ok, off_ok, in_rng;
    logic signed [3:0]  orow4, ocol4, pad4;
    logic signed [9:0]  nr10, nc10;
    logic [2:0]         ri, ci;
    logic [SX_W-1:0]    slot_calc;
    logic [FA_W-1:0]    base_calc;

    // Control and emission decode
    logic               put_ok, emit_ch, emit_last, in_ready;
    logic [SX_W-1:0]    emit_slot, slot_raddr;
    logic signed [15:0] slot_rd;
    logic [CI_W-1:0]    emit_ci;
    logic [E_W-1:0]     total_m1;

    logic [SQ_W:0]        sq_sum_t;
    logic signed [16:0]   slot_sum_t;
    logic [ACC_W:0]       acc_sum_t;
    logic [NUM_W-1:0]     num_sx;

    // Clamp the registers to the built sizes
    always_comb
    begin
        h_lim = (int'(map_height_reg) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : {2'b00, map_height_reg};
        w_lim = (int'(map_width_reg) > MAX_WIDTH) ? 9'(MAX_WIDTH) : {2'b00, map_width_reg};
        pad   = (int'(window_pad_reg) > MAX_PAD) ? 2'(MAX_PAD) : window_pad_reg;
        k_val = {pad, 1'b1};
        k2    = 5'({2'b00, k_val} * {2'b00, k_val});
        dch   = (int'(channel_count_reg) > MAX_CHANNELS) ? CN_W'(MAX_CHANNELS)
                                                          : CN_W'(channel_count_reg);
    end

    // Decode the incoming item
    always_comb
    begin
        accept     = item_in.valid && in_ready;
        accept_aff = accept && item_in.kind;
        load_ok    = (int'(item_in.pixel_row) < MAX_HEIGHT) &&
                     (int'(item_in.pixel_col) < MAX_WIDTH) &&
                     (int'(item_in.channel) < MAX_CHANNELS);
        feat_waddr = FA_W'((int'(item_in.pixel_row) * MAX_WIDTH + int'(item_in.pixel_col))
                           * MAX_CHANNELS + int'(item_in.channel));
        feat_we    = accept && !item_in.kind && load_ok;
        orow4      = {item_in.offset_row[2], item_in.offset_row};
        ocol4      = {item_in.offset_col[2], item_in.offset_col};
        pad4       = $signed({2'b00, pad});
        off_ok     = (orow4 >= -pad4) && (orow4 <= pad4) && (ocol4 >= -pad4) && (ocol4 <= pad4);
        nr10       = $signed({4'b0000, item_in.pixel_row}) + {{7{item_in.offset_row[2]}},
                                                             item_in.offset_row};
        nc10       = $signed({4'b0000, item_in.pixel_col}) + {{7{item_in.offset_col[2]}},
                                                             item_in.offset_col};
        in_rng     = off_ok && !nr10[9] && (nr10 < $signed({1'b0, h_lim})) &&
                     !nc10[9] && (nc10 < $signed({1'b0, w_lim}));
        ri         = 3'(orow4 + pad4);
        ci         = 3'(ocol4 + pad4);
        slot_calc  = SX_W'(int'(ri) * int'(k_val) + int'(ci));
        base_calc  = FA_W'((int'(nr10[7:0]) * MAX_WIDTH + int'(nc10[7:0])) * MAX_CHANNELS);
    end

    // Decode the emission position
    always_comb
    begin
        total_m1  = E_W'(dch) + E_W'(k2) - 1'b1;
        emit_ch   = (e_reg < E_W'(dch));
        emit_slot = SX_W'(e_reg - E_W'(dch));
        emit_ci   = CI_W'(e_reg);
        emit_last = (e_reg == total_m1);
        put_ok    = !out_valid_reg || result_out.ready;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lafa_pkg::S_IDLE:
            begin
                if (accept_aff)
                    state_next = lafa_pkg::S_LOAD;
            end
            lafa_pkg::S_LOAD:
            begin
                if (inrng_reg && (dch != '0))
                    state_next = lafa_pkg::S_ACC;
                else if (last_reg)
                    state_next = lafa_pkg::S_ROOT_GO;
                else
                    state_next = lafa_pkg::S_IDLE;
            end
            lafa_pkg::S_ACC:
            begin
                if (CN_W'(ch_reg) == dch - 1'b1)
                    state_next = lafa_pkg::S_DRAIN;
            end
            lafa_pkg::S_DRAIN:
            begin
                if (!p1_vld_reg && !p2_vld_reg)
                    state_next = last_reg ? lafa_pkg::S_ROOT_GO : lafa_pkg::S_IDLE;
            end
            lafa_pkg::S_ROOT_GO:
                state_next = lafa_pkg::S_ROOT_WAIT;
            lafa_pkg::S_ROOT_WAIT:
            begin
                if (norm_stat.done)
                    state_next = lafa_pkg::S_EMIT_RD;
            end
            lafa_pkg::S_EMIT_RD:
                state_next = lafa_pkg::S_EMIT_GO;
            lafa_pkg::S_EMIT_GO:
                state_next = lafa_pkg::S_EMIT_WAIT;
            lafa_pkg::S_EMIT_WAIT:
            begin
                if (norm_stat.done)
                    state_next = lafa_pkg::S_EMIT_PUT;
            end
            lafa_pkg::S_EMIT_PUT:
            begin
                if (put_ok)
                    state_next = emit_last ? lafa_pkg::S_IDLE : lafa_pkg::S_EMIT_RD;
            end
            default:
                state_next = lafa_pkg::S_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory addresses, unit requests, ready
    always_comb
    begin
        in_ready        = (state_reg == lafa_pkg::S_IDLE);
        feat_raddr      = base_reg + FA_W'(ch_reg);
        acc_raddr       = (state_reg == lafa_pkg::S_ACC) ? ch_reg : emit_ci;
        slot_raddr      = (state_reg == lafa_pkg::S_LOAD) ? slot_reg : emit_slot;
        norm_req.go_root = (state_reg == lafa_pkg::S_ROOT_GO);
        norm_req.go_div  = (state_reg == lafa_pkg::S_EMIT_GO);
        norm_req.square  = sq_sum_reg;
        slot_rd          = slot_val_reg[slot_raddr];
        if (emit_ch)
        begin
            num_sx = NUM_W'($signed({(acc_vld_reg[emit_ci] ? acc_rdata : ACC_W'(0)), 8'h00}));
            norm_req.neg = acc_vld_reg[emit_ci] && acc_rdata[ACC_W-1];
        end
        else
        begin
            num_sx = NUM_W'($signed({slot_rd, 16'h0000}));
            norm_req.neg = slot_rd[15];
        end
        norm_req.mag = norm_req.neg ? (NUM_W'(0) - num_sx) : num_sx;
    end

    // Saturating adders of the read-modify-write paths
    always_comb
    begin
        sq_sum_t   = {1'b0, sq_sum_reg} + (SQ_W + 1)'(sq_prod_reg);
        slot_sum_t = {slot_rd[15], slot_rd} + {aff_reg[15], aff_reg};
        acc_sum_t  = {accd_reg[ACC_W-1], accd_reg} + {{(ACC_W - 31){prod_reg[31]}}, prod_reg};
        if (acc_sum_t[ACC_W] != acc_sum_t[ACC_W-1])
            acc_wdata = acc_sum_t[ACC_W] ? {1'b1, {(ACC_W - 1){1'b0}}}
                                         : {1'b0, {(ACC_W - 1){1'b1}}};
        else
            acc_wdata = acc_sum_t[ACC_W-1:0];
        acc_we = p2_vld_reg;
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= lafa_pkg::S_IDLE;
            map_height_reg    <= lafa_pkg::MAP_HEIGHT_RST;
            map_width_reg     <= lafa_pkg::MAP_WIDTH_RST;
            window_pad_reg    <= lafa_pkg::WINDOW_PAD_RST;
            channel_count_reg <= lafa_pkg::CHANNEL_COUNT_RST;
            p1_vld_reg        <= 1'b0;
            p2_vld_reg        <= 1'b0;
            acc_vld_reg       <= '0;
            sq_sum_reg        <= '0;
            out_valid_reg     <= 1'b0;
            ch_reg            <= '0;
            e_reg             <= '0;
            for (int i = 0; i < SLOTS; i++)
                slot_val_reg[i] <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            p1_vld_reg <= (state_reg == lafa_pkg::S_ACC);
            p2_vld_reg <= p1_vld_reg;

            // Take configuration writes
            if (psel && penable && pwrite)
            begin
                case (lafa_pkg::reg_idx_t'(paddr[3:2]))
                    lafa_pkg::REG_MAP_HEIGHT:    map_height_reg    <= pwdata[6:0];
                    lafa_pkg::REG_MAP_WIDTH:     map_width_reg     <= pwdata[6:0];
                    lafa_pkg::REG_WINDOW_PAD:    window_pad_reg    <= pwdata[1:0];
                    lafa_pkg::REG_CHANNEL_COUNT: channel_count_reg <= pwdata[4:0];
                    default:                     map_height_reg    <= map_height_reg;
                endcase
            end

            // Advance the channel counter
            if (state_reg == lafa_pkg::S_ACC)
                ch_reg <= ch_reg + 1'b1;
            else
                ch_reg <= '0;

            // Update square sum and window slot
            if ((state_reg == lafa_pkg::S_LOAD) && inrng_reg)
            begin
                sq_sum_reg <= sq_sum_t[SQ_W] ? {SQ_W{1'b1}} : sq_sum_t[SQ_W-1:0];
                if (slot_sum_t[16] != slot_sum_t[15])
                    slot_val_reg[slot_reg] <= slot_sum_t[16] ? 16'sh8000 : 16'sh7fff;
                else
                    slot_val_reg[slot_reg] <= slot_sum_t[15:0];
            end

            if (acc_we)
                acc_vld_reg[p2_ch_reg] <= 1'b1;

            // Step through results
            if (state_reg == lafa_pkg::S_ROOT_GO)
                e_reg <= '0;

            if ((state_reg == lafa_pkg::S_EMIT_PUT) && put_ok)
            begin
                out_valid_reg <= 1'b1;
                e_reg         <= e_reg + 1'b1;
                if (emit_last)
                begin
                    // Drop the per-cell state
                    acc_vld_reg <= '0;
                    sq_sum_reg  <= '0;
                    for (int i = 0; i < SLOTS; i++)
                        slot_val_reg[i] <= '0;
                end
            end
            else if (out_valid_reg && result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept_aff)
        begin
            aff_reg     <= item_in.affinity;
            sq_prod_reg <= 32'(item_in.affinity * item_in.affinity);
            inrng_reg   <= in_rng;
            last_reg    <= item_in.window_last;
            slot_reg    <= slot_calc;
            base_reg    <= base_calc;
        end
        p1_ch_reg <= ch_reg;
        p2_ch_reg <= p1_ch_reg;
        prod_reg  <= aff_reg * $signed(feat_rdata);
        accd_reg  <= acc_vld_reg[p1_ch_reg] ? acc_rdata : ACC_W'(0);
        if ((state_reg == lafa_pkg::S_EMIT_WAIT) && norm_stat.done)
            res_hold_reg <= norm_stat.value;
        if ((state_reg == lafa_pkg::S_EMIT_PUT) && put_ok)
        begin
            out_kind_reg  <= !emit_ch;
            out_index_reg <= emit_ch ? 5'(emit_ci) : 5'(emit_slot);
            out_value_reg <= res_hold_reg;
            out_last_reg  <= emit_last;
        end
    end

    lafa_ram #(
        .WIDTH (lafa_pkg::FEAT_W),
        .DEPTH (FA_DEPTH)
    ) u_feat_ram (
        .clk   (clk),
        .we    (feat_we),
        .waddr (feat_waddr),
        .wdata (item_in.feature_value),
        .raddr (feat_raddr),
        .rdata (feat_rdata)
    );

    lafa_ram #(
        .WIDTH (ACC_W),
        .DEPTH (MAX_CHANNELS)
    ) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (p2_ch_reg),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    lafa_norm u_norm (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (norm_req),
        .stat  (norm_stat)
    );

    // Drive the ports
    assign item_in.ready           = in_ready;
    assign result_out.valid        = out_valid_reg;
    assign result_out.result_kind  = out_kind_reg;
    assign result_out.result_index = out_index_reg;
    assign result_out.result_value = out_value_reg;
    assign result_out.result_last  = out_last_reg;
    assign pready                  = 1'b1;

    always_comb
    begin
        case (lafa_pkg::reg_idx_t'(paddr[3:2]))
            lafa_pkg::REG_MAP_HEIGHT:    prdata = 32'(map_height_reg);
            lafa_pkg::REG_MAP_WIDTH:     prdata = 32'(map_width_reg);
            lafa_pkg::REG_WINDOW_PAD:    prdata = 32'(window_pad_reg);
            lafa_pkg::REG_CHANNEL_COUNT: prdata = 32'(channel_count_reg);
            default:                     prdata = '0;
        endcase
    end

    // Feature loads never collide with the accumulate reads
    assert property (@(posedge clk) disable iff (!rst_n)
        feat_we |-> !p1_vld_reg && !p2_vld_reg)
        else $error("feature write during accumulate");

    // Accumulator writes only come from an item in progress
    assert property (@(posedge clk) disable iff (!rst_n)
        acc_we |-> (state_reg == lafa_pkg::S_ACC || state_reg == lafa_pkg::S_DRAIN))
        else $error("accumulator write outside accumulate");

    // The unit reports only while the sequencer waits for it
    assert property (@(posedge clk) disable iff (!rst_n)
        norm_stat.done |-> (state_reg == lafa_pkg::S_ROOT_WAIT ||
                            state_reg == lafa_pkg::S_EMIT_WAIT))
        else $error("unexpected root or divide completion");

    // A loaded result is taken before the next one overwrites it
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lafa_pkg::S_EMIT_PUT && !put_ok) |=> $stable(out_value_reg))
        else $error("pending result overwritten");
endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for local_affinity_feature_assembly: loads features,
// streams window affinities, predicts every assembled result and compares it.
// Depends on lafa_pkg, lafa_item_if, lafa_result_if and the block's RTL.
module testbench;

    typedef struct {
        logic               kind;
        logic [5:0]         row;
        logic [5:0]         col;
        logic [3:0]         chan;
        logic signed [15:0] feat;
        logic signed [2:0]  orow;
        logic signed [2:0]  ocol;
        logic signed [15:0] aff;
        logic               last;
    } item_t;

    typedef struct {
        logic               rkind;
        logic [4:0]         idx;
        logic signed [31:0] value;
        logic               last;
    } result_t;

    // Predicts assembled features and normalised affinities per output cell
    class cell_scoreboard;
        shortint feat_mem [65536];
        longint  chan_acc [16];
        longint  square_acc;
        longint  slot_acc [25];
        int      reg_h = 64, reg_w = 64, reg_pad = 1, reg_chans = 16;
        result_t expected_q [$];
        int      errors = 0;

        function void set_reg(lafa_pkg::reg_idx_t idx, int val);
            case (idx)
                lafa_pkg::REG_MAP_HEIGHT:    reg_h = val & 'h7f;
                lafa_pkg::REG_MAP_WIDTH:     reg_w = val & 'h7f;
                lafa_pkg::REG_WINDOW_PAD:    reg_pad = val & 'h3;
                lafa_pkg::REG_CHANNEL_COUNT: reg_chans = val & 'h1f;
                default: ;
            endcase
        endfunction

        function longint int_root(longint s);
            longint r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > s) b = b >> 2;
            while (b != 0)
            begin
                if (s >= r + b)
                begin
                    s = s - (r + b);
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function logic [31:0] round_div(longint num, longint den);
            longint mag, q;
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            if (num >= 0)
                return (q > 64'h7fffffff) ? 32'h7fffffff : q[31:0];
            return (q > 64'h80000000) ? 32'h80000000 : 32'(-q);
        endfunction

        function void note_item(item_t it);
            int h, w, p, k, d, nr, nc, slot, base;
            longint a, root;
            result_t r;
            if (it.kind == 1'b0)
            begin
                feat_mem[{it.row, it.col, it.chan}] = it.feat;
                return;
            end
            h = reg_h < 64 ? reg_h : 64;
            w = reg_w < 64 ? reg_w : 64;
            p = reg_pad < 2 ? reg_pad : 2;
            k = 2 * p + 1;
            d = reg_chans < 16 ? reg_chans : 16;
            a = it.aff;
            nr = int'(it.row) + int'(it.orow);
            nc = int'(it.col) + int'(it.ocol);
            // Accumulate only neighbours inside both the window and the map
            if (it.orow >= -p && it.orow <= p && it.ocol >= -p && it.ocol <= p &&
                nr >= 0 && nr < h && nc >= 0 && nc < w)
            begin
                base = (nr * 64 + nc) * 16;
                slot = (int'(it.orow) + p) * k + (int'(it.ocol) + p);
                for (int c = 0; c < d; c++)
                begin
                    chan_acc[c] = chan_acc[c] + a * longint'(feat_mem[base + c]);
                    if (chan_acc[c] > (64'sd1 <<< 47) - 1) chan_acc[c] = (64'sd1 <<< 47) - 1;
                    if (chan_acc[c] < -(64'sd1 <<< 47)) chan_acc[c] = -(64'sd1 <<< 47);
                end
                square_acc = square_acc + a * a;
                if (square_acc > (64'sd1 <<< 40) - 1) square_acc = (64'sd1 <<< 40) - 1;
                slot_acc[slot] = slot_acc[slot] + a;
                if (slot_acc[slot] > 32767) slot_acc[slot] = 32767;
                if (slot_acc[slot] < -32768) slot_acc[slot] = -32768;
            end
            if (!it.last)
                return;
            root = int_root(square_acc);
            if (root == 0) root = 1;
            for (int c = 0; c < d; c++)
            begin
                r.rkind = 1'b0;
                r.idx = 5'(c);
                r.value = round_div(chan_acc[c] * 256, root);
                r.last = 1'b0;
                expected_q.push_back(r);
            end
            for (int s = 0; s < k * k; s++)
            begin
                r.rkind = 1'b1;
                r.idx = 5'(s);
                r.value = round_div(slot_acc[s] * 65536, root);
                r.last = (s == k * k - 1);
                expected_q.push_back(r);
            end
            // Drop all per-cell state
            foreach (chan_acc[c]) chan_acc[c] = 0;
            foreach (slot_acc[s]) slot_acc[s] = 0;
            square_acc = 0;
        endfunction

        function void check(result_t got);
            result_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d index %0d value %0d", $time,
                         got.rkind, got.idx, got.value);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (got.rkind !== e.rkind || got.idx !== e.idx || got.value !== e.value ||
                got.last !== e.last)
            begin
                $display("%0t: mismatch expected kind %0d idx %0d value %0d last %0d",
                         $time, e.rkind, e.idx, e.value, e.last);
                $display("%0t:          actual   kind %0d idx %0d value %0d last %0d",
                         $time, got.rkind, got.idx, got.value, got.last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel, penable, pwrite;
    logic [lafa_pkg::PADDR_W-1:0] paddr;
    logic [lafa_pkg::PDATA_W-1:0] pwdata;
    logic [lafa_pkg::PDATA_W-1:0] prdata;
    logic        pready;

    lafa_item_if   item_bus ();
    lafa_result_if result_bus ();

    local_affinity_feature_assembly dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_bus.sink),
        .result_out (result_bus.source),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    cell_scoreboard sb = new();
    bit pix_loaded [4096];
    int cur_h = 64, cur_w = 64, cur_pad = 1;
    bit send_burst = 0, recv_burst = 0;
    int stim_count = 0;

    always #5 clk = ~clk;

    // Check each result transaction against the oldest prediction
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
        begin
            got.rkind = result_bus.result_kind;
            got.idx = result_bus.result_index;
            got.value = result_bus.result_value;
            got.last = result_bus.result_last;
            sb.check(got);
        end
    end

    // Receiver: unless in a burst, stall at random before each result
    initial
    begin
        int gap;
        result_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = recv_burst ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            do @(posedge clk); while (!(result_bus.valid === 1'b1));
        end
    end

    task automatic send_item(item_t it);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid         <= 1'b1;
        item_bus.kind          <= it.kind;
        item_bus.pixel_row     <= it.row;
        item_bus.pixel_col     <= it.col;
        item_bus.channel       <= it.chan;
        item_bus.feature_value <= it.feat;
        item_bus.offset_row    <= it.orow;
        item_bus.offset_col    <= it.ocol;
        item_bus.affinity      <= it.aff;
        item_bus.window_last   <= it.last;
        do @(posedge clk); while (item_bus.ready !== 1'b1);
        sb.note_item(it);
        stim_count++;
    endtask

    function automatic logic signed [15:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 63) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // Load every channel of a neighbour pixel the first time a window reads it
    task automatic send_affinity(int row, int col, int orow, int ocol,
                                 logic signed [15:0] aff, bit last);
        item_t it;
        int p, nr, nc;
        p = cur_pad < 2 ? cur_pad : 2;
        nr = row + orow;
        nc = col + ocol;
        if (orow >= -p && orow <= p && ocol >= -p && ocol <= p && nr >= 0 && nc >= 0 &&
            nr < (cur_h < 64 ? cur_h : 64) && nc < (cur_w < 64 ? cur_w : 64) &&
            !pix_loaded[nr * 64 + nc])
        begin
            for (int c = 0; c < 16; c++)
            begin
                it = '{1'b0, nr[5:0], nc[5:0], c[3:0], rand_word(), 3'($urandom),
                       3'($urandom), 16'($urandom), 1'($urandom)};
                send_item(it);
            end
            pix_loaded[nr * 64 + nc] = 1'b1;
        end
        it = '{1'b1, row[5:0], col[5:0], 4'($urandom), 16'($urandom), orow[2:0], ocol[2:0],
               aff, last};
        send_item(it);
    endtask

    task automatic write_reg(lafa_pkg::reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= lafa_pkg::PADDR_W'(int'(idx) * 4);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, val);
        case (idx)
            lafa_pkg::REG_MAP_HEIGHT: cur_h = val & 'h7f;
            lafa_pkg::REG_MAP_WIDTH:  cur_w = val & 'h7f;
            lafa_pkg::REG_WINDOW_PAD: cur_pad = val & 'h3;
            default: ;
        endcase
    endtask

    // Hold the input side until every result has come and the block is quiet
    task automatic drain();
        @(posedge clk);
        item_bus.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (64) @(posedge clk);
    endtask

    task automatic send_window(int row, int col);
        int p, k;
        p = cur_pad < 2 ? cur_pad : 2;
        k = 2 * p + 1;
        if ($urandom_range(0, 4) != 0)
        begin
            // Well-formed window in row-major order
            for (int i = 0; i < k * k; i++)
                send_affinity(row, col, i / k - p, i % k - p, rand_word(), i == k * k - 1);
        end
        else
        begin
            // Noise: any offsets, repeated slots, short windows
            int n;
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                send_affinity(row, col, $urandom_range(0, 7) - 4, $urandom_range(0, 7) - 4,
                              rand_word(), i == n - 1);
        end
    endtask

    function automatic int pick_coord(int n);
        int v;
        case ($urandom_range(0, 5))
            0: v = 0;
            1: v = 1;
            2: v = n - 1;
            3: v = n - 2;
            4: v = 63;
            default: v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : 2;
        endcase
        return v < 0 ? 0 : (v > 63 ? 63 : v);
    endfunction

    // Generous fixed limit on the whole run
    initial
    begin
        #30_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int hs [8] = '{1, 64, 127, 0, 2, 17, 64, 5};
        int ws [8] = '{64, 1, 3, 127, 0, 64, 9, 2};
        int ps [8] = '{0, 2, 3, 1, 2, 0, 1, 2};
        int cs [8] = '{16, 0, 31, 1, 7, 16, 3, 12};
        int phase, start;
        item_t it;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        item_bus.valid <= 1'b0;
        item_bus.kind <= 1'b0;
        item_bus.pixel_row <= '0;
        item_bus.pixel_col <= '0;
        item_bus.channel <= '0;
        item_bus.feature_value <= '0;
        item_bus.offset_row <= '0;
        item_bus.offset_col <= '0;
        item_bus.affinity <= '0;
        item_bus.window_last <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme affinities at a corner, out-of-map neighbours
        send_affinity(0, 0, -1, -1, 16'sh7fff, 0);
        send_affinity(0, 0, 0, 0, 16'sh8000, 0);
        send_affinity(0, 0, 0, 1, 16'sh7fff, 0);
        send_affinity(0, 0, 1, 1, 16'sh0001, 1);
        // Repeated slot and an offset beyond the window
        send_affinity(0, 0, 0, 0, 16'sh7fff, 0);
        send_affinity(0, 0, 0, 0, 16'sh7fff, 0);
        send_affinity(0, 0, 2, 0, 16'sh1234, 1);
        // Window_last on a feature load is ignored; all-zero window gives root of one
        it = '{1'b0, 6'd63, 6'd63, 4'd15, 16'sh8000, 3'd0, 3'd0, 16'sh0, 1'b1};
        send_item(it);
        send_affinity(63, 63, 0, 0, 16'sh0000, 0);
        send_affinity(63, 63, 1, 1, 16'sh7fff, 1);
        drain();

        phase = 0;
        while (stim_count < 410)
        begin
            write_reg(lafa_pkg::REG_MAP_HEIGHT, hs[phase % 8]);
            write_reg(lafa_pkg::REG_MAP_WIDTH, ws[phase % 8]);
            write_reg(lafa_pkg::REG_WINDOW_PAD, ps[phase % 8]);
            write_reg(lafa_pkg::REG_CHANNEL_COUNT, cs[phase % 8]);
            send_burst = ($urandom_range(0, 3) == 0);
            recv_burst = ($urandom_range(0, 3) == 0);
            start = stim_count;
            while (stim_count - start < 55 && stim_count < 410)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // Refresh a word of a loaded pixel, sometimes flagged last
                    it = '{1'b0, 6'd2, 6'd2, 4'($urandom), rand_word(), 3'($urandom),
                           3'($urandom), 16'($urandom), 1'($urandom)};
                    if (pix_loaded[2 * 64 + 2]) send_item(it);
                end
                send_window(pick_coord(cur_h), pick_coord(cur_w));
            end
            drain();
            phase++;
        end

        drain();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

[filelist.f]
design/lafa_pkg.sv
design/lafa_item_if.sv
design/lafa_result_if.sv
design/lafa_ram.sv
design/lafa_norm.sv
design/local_affinity_feature_assembly.sv
sim/testbench.sv
